// ----- rtl/wcdl_pkg.sv -----
// Package for the wakeup coalescing duty limiter.
// Holds mode and register codes, reset values, the shared item types and
// the wrap-safe time compare. No dependencies.
package wcdl_pkg;

   localparam int TIME_W     = 32;
   localparam int MS_W       = 16;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int GAP_W      = 24;

   // input item modes
   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TRIGGER  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POSTPONE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PASS     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP     = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_FACTOR     = 2'd2;

   // configuration reset values
   localparam logic [MS_W-1:0] MIN_INTERVAL_RST   = 16'd300;
   localparam logic [MS_W-1:0] FULL_THRESHOLD_RST = 16'd10;
   localparam logic [MS_W-1:0] GAP_FACTOR_RST     = 16'd2588;

   // rounding half step for the Q8.8 gap product
   localparam logic [TIME_W-1:0] Q8_HALF = 32'd128;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [MS_W-1:0]   delay_ms;
      logic [MS_W-1:0]   pass_ms;
      logic              pass_finished;
   } req_item_type;

   typedef struct packed {
      logic start_pass;
      logic sliced;
      logic new_cycle;
      logic idle;
   } rsp_item_type;

   typedef struct packed {
      logic [MS_W-1:0] min_interval_ms;
      logic [MS_W-1:0] full_threshold_ms;
      logic [MS_W-1:0] gap_factor_q8;
   } cfg_type;

   // a strictly before b on the wrapping time base
   function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

endpackage

// ----- rtl/wcdl_if.sv -----
// Channel interfaces for the wakeup coalescing duty limiter: request,
// response and register write channels, each with source and sink modports.
// Depends on wcdl_pkg.
interface wcdl_req_if import wcdl_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [MS_W-1:0]   delay_ms;
   logic [MS_W-1:0]   pass_ms;
   logic              pass_finished;
   modport source (output valid, mode, delay_ms, pass_ms, pass_finished, input ready);
   modport sink   (input valid, mode, delay_ms, pass_ms, pass_finished, output ready);
endinterface

interface wcdl_rsp_if;
   logic valid;
   logic ready;
   logic start_pass;
   logic sliced;
   logic new_cycle;
   logic idle;
   modport source (output valid, start_pass, sliced, new_cycle, idle, input ready);
   modport sink   (input valid, start_pass, sliced, new_cycle, idle, output ready);
endinterface

interface wcdl_csr_if import wcdl_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [MS_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/wakeup_coalescing_duty_limiter.sv -----
// Wakeup coalescing duty limiter. Takes one request (tick, trigger, postpone
// trigger, pass done or stop) per clock and returns exactly one response for
// each, in order. A request is held in the input register while the scheduler
// state is updated from it in a single pass; its response is loaded into the
// result register at the same edge as that state update, and sustained
// throughput is one request per cycle while the response side keeps up. While
// a finished response waits, the input register can take one more request and
// then the request side stalls until the response transfers. Registers
// should only be written while no request is in flight.
// Depends on wcdl_pkg, the channel interfaces and the wcdl_* submodules.
module wakeup_coalescing_duty_limiter
   import wcdl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   wcdl_req_if.sink      req_ch,
   wcdl_rsp_if.source    rsp_ch,
   wcdl_csr_if.sink      csr_ch
);

   cfg_type      cfg;
   req_item_type item;
   rsp_item_type result;
   logic         item_valid;
   logic         room;
   logic         advance;

   // an item moves on when the result register can take its response
   assign advance = item_valid && room;

   wcdl_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   wcdl_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   wcdl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .result  (result)
   );

   wcdl_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (advance),
      .result (result),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- rtl/wcdl_csr.sv -----
// Configuration registers of the duty limiter, written over the csr channel.
// Depends on wcdl_pkg and wcdl_csr_if.
module wcdl_csr
   import wcdl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   wcdl_csr_if.sink        csr_ch,
   output cfg_type         cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MIN_INTERVAL:   cfg_in.min_interval_ms   = csr_ch.data;
            CSR_FULL_THRESHOLD: cfg_in.full_threshold_ms = csr_ch.data;
            CSR_GAP_FACTOR:     cfg_in.gap_factor_q8     = csr_ch.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval_ms   <= MIN_INTERVAL_RST;
         cfg_ff.full_threshold_ms <= FULL_THRESHOLD_RST;
         cfg_ff.gap_factor_q8     <= GAP_FACTOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/wcdl_in_stage.sv -----
// Input register of the duty limiter: captures one request transfer and
// holds it until the scheduler consumes it. Depends on wcdl_pkg, wcdl_req_if.
module wcdl_in_stage
   import wcdl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   wcdl_req_if.sink      req_ch,
   input  logic          advance,
   output logic          item_valid,
   output req_item_type  item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   // empty, or draining this cycle
   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.mode          <= req_ch.mode;
         item_ff.delay_ms      <= req_ch.delay_ms;
         item_ff.pass_ms       <= req_ch.pass_ms;
         item_ff.pass_finished <= req_ch.pass_finished;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/wcdl_core.sv -----
// Scheduler state of the duty limiter and its single-pass update for one
// item: tick, trigger, postpone, pass done and stop. Depends on wcdl_pkg.
module wcdl_core
   import wcdl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  req_item_type  item,
   input  cfg_type       cfg,
   output rsp_item_type  result
);

   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [TIME_W-1:0] last_start_ff, last_start_in;
   logic [TIME_W-1:0] gate_ff, gate_in;
   logic [TIME_W-1:0] cost_ff, cost_in;
   logic [TIME_W-1:0] last_cost_ff, last_cost_in;
   logic              pending_ff, pending_in;
   logic              started_ff, started_in;
   logic              busy_ff, busy_in;
   logic              stopped_ff, stopped_in;
   logic              open_ff, open_in;

   logic [TIME_W-1:0] now_inc;
   logic [TIME_W-1:0] tick_diff;
   logic              due;
   logic [TIME_W-1:0] cand_raw;
   logic [TIME_W-1:0] floor_ms;
   logic [TIME_W-1:0] cand;
   logic [TIME_W-1:0] merged;
   logic [TIME_W-1:0] prod;
   logic [TIME_W-1:0] prod_rnd;
   logic [GAP_W-1:0]  gap;
   logic [TIME_W:0]   cost_sum;
   logic [TIME_W-1:0] cost_sat;

   // tick: due when deadline minus advanced time is zero or negative
   assign now_inc   = now_ff + 32'd1;
   assign tick_diff = deadline_ff - now_inc;
   assign due       = tick_diff[TIME_W-1] || (tick_diff == '0);

   // trigger: candidate, held off by the minimum interval
   assign cand_raw = now_ff + {{(TIME_W-MS_W){1'b0}}, item.delay_ms};
   assign floor_ms = last_start_ff + {{(TIME_W-MS_W){1'b0}}, cfg.min_interval_ms};
   assign cand     = (started_ff && earlier(cand_raw, floor_ms)) ? floor_ms : cand_raw;

   always_comb begin
      if (!pending_ff) begin
         merged = cand;
      end else if (item.mode == MODE_POSTPONE) begin
         merged = earlier(deadline_ff, cand) ? cand : deadline_ff;
      end else begin
         merged = earlier(deadline_ff, cand) ? deadline_ff : cand;
      end
   end

   // pass done: gap rounds half up; it stays below 2^24 so the gate never
   // falls before the current time
   assign prod     = TIME_W'(item.pass_ms) * TIME_W'(cfg.gap_factor_q8);
   assign prod_rnd = prod + Q8_HALF;
   assign gap      = prod_rnd[GAP_W+7:8];
   assign cost_sum = {1'b0, cost_ff} + {{(TIME_W-MS_W+1){1'b0}}, item.pass_ms};
   assign cost_sat = cost_sum[TIME_W] ? {TIME_W{1'b1}} : cost_sum[TIME_W-1:0];

   // next state and result
   always_comb begin
      now_in        = now_ff;
      deadline_in   = deadline_ff;
      last_start_in = last_start_ff;
      gate_in       = gate_ff;
      cost_in       = cost_ff;
      last_cost_in  = last_cost_ff;
      pending_in    = pending_ff;
      started_in    = started_ff;
      busy_in       = busy_ff;
      stopped_in    = stopped_ff;
      open_in       = open_ff;
      result        = '0;
      case (item.mode)
         MODE_TICK: begin
            now_in = now_inc;
            if (!stopped_ff && !busy_ff && pending_ff && due) begin
               pending_in        = 1'b0;
               last_start_in     = now_inc;
               started_in        = 1'b1;
               busy_in           = 1'b1;
               result.start_pass = 1'b1;
               result.sliced     = last_cost_ff > {{(TIME_W-MS_W){1'b0}},
                                                   cfg.full_threshold_ms};
               result.new_cycle  = !open_ff;
            end
         end
         MODE_TRIGGER, MODE_POSTPONE: begin
            deadline_in = earlier(merged, gate_ff) ? gate_ff : merged;
            pending_in  = 1'b1;
         end
         MODE_PASS: begin
            if (busy_ff) begin
               gate_in = now_ff + {{(TIME_W-GAP_W){1'b0}}, gap};
               busy_in = 1'b0;
               open_in = !item.pass_finished;
               if (!item.pass_finished) begin
                  cost_in     = cost_sat;
                  pending_in  = 1'b1;
                  deadline_in = gate_in;
               end else begin
                  last_cost_in = cost_sat;
                  cost_in      = '0;
               end
            end
         end
         MODE_STOP: begin
            stopped_in = 1'b1;
         end
         default: begin
            now_in = now_ff;
         end
      endcase
      result.idle = !pending_in && !busy_in && !stopped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         deadline_ff   <= '0;
         last_start_ff <= '0;
         gate_ff       <= '0;
         cost_ff       <= '0;
         last_cost_ff  <= '0;
         pending_ff    <= 1'b0;
         started_ff    <= 1'b0;
         busy_ff       <= 1'b0;
         stopped_ff    <= 1'b0;
         open_ff       <= 1'b0;
      end else if (advance) begin
         now_ff        <= now_in;
         deadline_ff   <= deadline_in;
         last_start_ff <= last_start_in;
         gate_ff       <= gate_in;
         cost_ff       <= cost_in;
         last_cost_ff  <= last_cost_in;
         pending_ff    <= pending_in;
         started_ff    <= started_in;
         busy_ff       <= busy_in;
         stopped_ff    <= stopped_in;
         open_ff       <= open_in;
      end
   end

endmodule

// ----- rtl/wcdl_out_stage.sv -----
// Result register of the duty limiter, driving the response channel.
// Depends on wcdl_pkg and wcdl_rsp_if.
module wcdl_out_stage
   import wcdl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_item_type  result,
   output logic          room,
   wcdl_rsp_if.source    rsp_ch
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   // free, or being emptied by a transfer this cycle
   assign room = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.start_pass = data_ff.start_pass;
   assign rsp_ch.sliced     = data_ff.sliced;
   assign rsp_ch.new_cycle  = data_ff.new_cycle;
   assign rsp_ch.idle       = data_ff.idle;

endmodule

// ----- rtl/wcdl_checker.sv -----
// Port-level checks for the wakeup coalescing duty limiter, bound to the
// top level. Depends only on the top level's channel signals.
module wcdl_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic start_pass,
   input logic sliced,
   input logic new_cycle,
   input logic idle
);

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({start_pass, sliced, new_cycle, idle}))
      else $error("stalled response changed");

   // slice and cycle flags only come with a started run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (sliced || new_cycle) |-> start_pass)
      else $error("run flags without a start");

   // a started run leaves the block busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_pass |-> !idle)
      else $error("idle reported with a run just started");

   // an accepted request is followed by a valid response, through the input and
   // result registers, when the response side never stalls
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready && $past(rsp_ready) |=> ##1 rsp_valid)
      else $error("response missing after accepted request");

endmodule

bind wakeup_coalescing_duty_limiter wcdl_checker u_wcdl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .start_pass (rsp_ch.start_pass),
   .sliced     (rsp_ch.sliced),
   .new_cycle  (rsp_ch.new_cycle),
   .idle       (rsp_ch.idle)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for wakeup_coalescing_duty_limiter: directed and random
// request streams are scored against a cycle-free scheduler predictor.
// Depends on wcdl_pkg, the wcdl channel interfaces and the top-level RTL.
module tb;
   import wcdl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int LATENCY_SLACK = 6;

   logic clock;
   logic reset;

   wcdl_req_if req_ch ();
   wcdl_rsp_if rsp_ch ();
   wcdl_csr_if csr_ch ();

   wakeup_coalescing_duty_limiter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // predictor copy of the register file
   logic [MS_W-1:0] cfg_min_gap;
   logic [MS_W-1:0] cfg_slice_limit;
   logic [MS_W-1:0] cfg_gap_factor;

   // predictor copy of the scheduler state
   logic [TIME_W-1:0] clk_ms;
   logic [TIME_W-1:0] due_ms;
   logic              run_wanted;
   logic [TIME_W-1:0] last_launch_ms;
   logic              launched_once;
   logic [TIME_W-1:0] gate_ms;
   logic              running;
   logic              halted;
   logic              cycle_open;
   logic [TIME_W-1:0] cycle_cost_ms;
   logic [TIME_W-1:0] prev_cycle_cost_ms;

   rsp_item_type pending_rsp[$];

   string rsp_field_name [0:3] = '{"idle", "new_cycle", "sliced", "start_pass"};

   int          error_count;
   int          req_count;
   int          rsp_count;
   int          csr_count;
   int          start_count;
   int          sliced_count;
   int          fresh_count;
   int unsigned cycle_count;

   bit idling_on;
   int hold_request;
   int hold_left;
   int stall_left;

   // wrap-safe time ordering: a strictly earlier than b
   function automatic logic precedes(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

   function automatic logic [TIME_W-1:0] latest(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
      return precedes(a, b) ? b : a;
   endfunction

   function automatic logic [TIME_W-1:0] earliest(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
      return precedes(a, b) ? a : b;
   endfunction

   // advance the predicted scheduler by one request, return its response
   function automatic rsp_item_type pace_step(input req_item_type it);
      rsp_item_type      r;
      logic [TIME_W-1:0] cand;
      logic [TIME_W-1:0] lag;
      logic [TIME_W-1:0] prod;
      logic [TIME_W:0]   cost_sum;
      r = '0;
      case (it.mode)
         MODE_TICK: begin
            clk_ms = clk_ms + 1'b1;
            lag = due_ms - clk_ms;
            if (!halted && !running && run_wanted && $signed(lag) < 1) begin
               r.start_pass   = 1'b1;
               r.sliced       = prev_cycle_cost_ms > TIME_W'(cfg_slice_limit);
               r.new_cycle    = !cycle_open;
               run_wanted     = 1'b0;
               last_launch_ms = clk_ms;
               launched_once  = 1'b1;
               running        = 1'b1;
            end
         end
         MODE_TRIGGER, MODE_POSTPONE: begin
            cand = clk_ms + TIME_W'(it.delay_ms);
            if (launched_once)
               cand = latest(cand, last_launch_ms + TIME_W'(cfg_min_gap));
            if (!run_wanted)
               due_ms = cand;
            else if (it.mode == MODE_POSTPONE)
               due_ms = latest(due_ms, cand);
            else
               due_ms = earliest(due_ms, cand);
            due_ms = latest(due_ms, gate_ms);
            run_wanted = 1'b1;
         end
         MODE_PASS: begin
            // ignored unless a run is in progress
            if (running) begin
               prod = TIME_W'(it.pass_ms) * TIME_W'(cfg_gap_factor) + Q8_HALF;
               gate_ms = clk_ms + (prod >> 8);
               cost_sum = {1'b0, cycle_cost_ms} + (TIME_W+1)'(it.pass_ms);
               cycle_cost_ms = cost_sum[TIME_W] ? '1 : cost_sum[TIME_W-1:0];
               running = 1'b0;
               cycle_open = !it.pass_finished;
               if (cycle_open) begin
                  run_wanted = 1'b1;
                  due_ms = latest(gate_ms, clk_ms);
               end else begin
                  prev_cycle_cost_ms = cycle_cost_ms;
                  cycle_cost_ms = '0;
               end
            end
         end
         MODE_STOP: halted = 1'b1;
         default: ;
      endcase
      r.idle = !run_wanted && !running && !halted;
      return r;
   endfunction

   // observe transfers on all three channels, predict and score
   always @(posedge clock) begin : scoreboard
      req_item_type it;
      rsp_item_type want;
      rsp_item_type got;
      logic [3:0]   want_bits;
      logic [3:0]   got_bits;
      if (reset) begin
         cfg_min_gap        = MIN_INTERVAL_RST;
         cfg_slice_limit    = FULL_THRESHOLD_RST;
         cfg_gap_factor     = GAP_FACTOR_RST;
         clk_ms             = '0;
         due_ms             = '0;
         run_wanted         = 1'b0;
         last_launch_ms     = '0;
         launched_once      = 1'b0;
         gate_ms            = '0;
         running            = 1'b0;
         halted             = 1'b0;
         cycle_open         = 1'b0;
         cycle_cost_ms      = '0;
         prev_cycle_cost_ms = '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            csr_count++;
            case (csr_ch.index)
               CSR_MIN_INTERVAL:   cfg_min_gap = csr_ch.data;
               CSR_FULL_THRESHOLD: cfg_slice_limit = csr_ch.data;
               CSR_GAP_FACTOR:     cfg_gap_factor = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            it.mode          = req_ch.mode;
            it.delay_ms      = req_ch.delay_ms;
            it.pass_ms       = req_ch.pass_ms;
            it.pass_finished = req_ch.pass_finished;
            want = pace_step(it);
            pending_rsp.push_back(want);
            req_count++;
            start_count  += want.start_pass;
            sliced_count += want.sliced;
            fresh_count  += want.new_cycle;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            got.start_pass = rsp_ch.start_pass;
            got.sliced     = rsp_ch.sliced;
            got.new_cycle  = rsp_ch.new_cycle;
            got.idle       = rsp_ch.idle;
            if (pending_rsp.size() == 0) begin
               error_count++;
               $display("%0t: response with none expected: expected nothing, actual %b",
                        $time, got);
            end else begin
               want = pending_rsp.pop_front();
               want_bits = want;
               got_bits = got;
               for (int i = 3; i >= 0; i--) begin
                  if (got_bits[i] !== want_bits[i]) begin
                     error_count++;
                     $display("%0t: response %0d field %s: expected %b, actual %b",
                              $time, rsp_count, rsp_field_name[i], want_bits[i], got_bits[i]);
                  end
               end
            end
         end
      end
   end

   // response side: random stall bursts plus requested long hold-offs
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idling_on && !reset && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, pending_rsp.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one request transfer; valid stays high for a back-to-back follower
   task automatic send_req(input logic [MODE_W-1:0] mode, input logic [MS_W-1:0] delay,
                           input logic [MS_W-1:0] pass, input logic fin);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= mode;
      req_ch.delay_ms      <= delay;
      req_ch.pass_ms       <= pass;
      req_ch.pass_finished <= fin;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic tick_for(input int n);
      repeat (n) send_req(MODE_TICK, MS_W'($urandom_range(0, 65535)),
                          MS_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endtask

   // drop valid and wait for every outstanding response
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic program_regs(input logic [MS_W-1:0] min_gap, input logic [MS_W-1:0] thr,
                               input logic [MS_W-1:0] gap_q8);
      settle();
      write_csr(CSR_MIN_INTERVAL, min_gap);
      write_csr(CSR_FULL_THRESHOLD, thr);
      write_csr(CSR_GAP_FACTOR, gap_q8);
   endtask

   // reset settings: first run, continuation, stray pass done, unused modes
   task automatic test_first_run();
      send_req(MODE_TRIGGER, 16'd0, 16'd0, 1'b0);
      tick_for(1);
      send_req(MODE_PASS, 16'd0, 16'd0, 1'b0);
      tick_for(1);
      send_req(MODE_PASS, 16'd0, 16'd1, 1'b1);
      send_req(MODE_PASS, 16'hFFFF, 16'hFFFF, 1'b1);
      send_req(3'd5, 16'hFFFF, 16'hFFFF, 1'b1);
      send_req(3'd6, 16'h0000, 16'h0000, 1'b0);
      send_req(3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
   endtask

   // zero threshold: sliced start; far trigger, postpone, then pull-in
   task automatic test_slicing();
      program_regs(16'd2, 16'd0, 16'd256);
      send_req(MODE_TRIGGER, 16'hFFFF, 16'd0, 1'b0);
      send_req(MODE_POSTPONE, 16'd3, 16'd0, 1'b0);
      send_req(MODE_TRIGGER, 16'd0, 16'd0, 1'b0);
      tick_for(11);
      send_req(MODE_PASS, 16'd0, 16'd2, 1'b1);
   endtask

   // largest interval and threshold, then interval zero and largest gap factor
   task automatic test_interval_extremes();
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_req(MODE_TRIGGER, 16'd0, 16'd0, 1'b0);
      tick_for(3);
      send_req(MODE_PASS, 16'd0, 16'd1, 1'b1);
      settle();
      write_csr(CSR_MIN_INTERVAL, 16'd0);
      send_req(MODE_TRIGGER, 16'd0, 16'd0, 1'b0);
      tick_for(1);
      send_req(MODE_PASS, 16'd0, 16'd1, 1'b1);
   endtask

   // long response hold-off while requests keep coming
   task automatic test_backpressure();
      settle();
      idling_on = 1'b0;
      hold_request = 80;
      for (int i = 0; i < 40; i++)
         send_req((i % 5 == 0) ? MODE_TRIGGER : MODE_TICK, MS_W'($urandom_range(0, 8)),
                  MS_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      settle();
      idling_on = 1'b1;
   endtask

   // one configuration, mostly trigger-run-pass sequences, some noise
   task automatic random_phase(input logic [MS_W-1:0] min_gap, input logic [MS_W-1:0] thr,
                               input logic [MS_W-1:0] gap_q8, input int pass_max,
                               input int delay_max, input int count);
      int first;
      int m;
      program_regs(min_gap, thr, gap_q8);
      first = req_count;
      while (req_count - first < count) begin
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 2))
               send_req($urandom_range(0, 1) ? MODE_POSTPONE : MODE_TRIGGER,
                        MS_W'($urandom_range(0, delay_max)), MS_W'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)));
            tick_for($urandom_range(1, 30));
            send_req(MODE_PASS, MS_W'($urandom_range(0, 65535)),
                     MS_W'($urandom_range(0, pass_max)), 1'($urandom_range(0, 1)));
            tick_for($urandom_range(0, 10));
         end else begin
            // noise: any mode but stop, full-range delays
            repeat ($urandom_range(1, 4)) begin
               m = $urandom_range(0, 6);
               if (m >= int'(MODE_STOP))
                  m++;
               send_req(MODE_W'(m), MS_W'($urandom_range(0, 65535)),
                        MS_W'($urandom_range(0, pass_max)), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   task automatic test_random_mix();
      random_phase(16'd0, 16'd0, 16'd0, 40, 10, 200);
      random_phase(16'd3, 16'd20, 16'd64, 200, 20, 200);
      random_phase(16'd20, 16'hFFFF, 16'd1, 65535, 15, 200);
      random_phase(16'd1, 16'd50, 16'd512, 30, 10, 200);
      settle();
      idling_on = 1'b0;
      random_phase(16'd5, 16'd10, 16'd256, 25, 10, 200);
   endtask

   // largest pass at largest factor, then stop; nothing may start after it
   task automatic test_stop();
      program_regs(16'd0, 16'd10, 16'd0);
      send_req(MODE_PASS, 16'd0, 16'd0, 1'b1);
      send_req(MODE_TRIGGER, 16'd0, 16'd0, 1'b0);
      tick_for(30);
      settle();
      write_csr(CSR_GAP_FACTOR, 16'hFFFF);
      send_req(MODE_PASS, 16'd0, 16'hFFFF, 1'b0);
      send_req(MODE_POSTPONE, 16'hFFFF, 16'd0, 1'b0);
      send_req(MODE_STOP, 16'hFFFF, 16'hFFFF, 1'b1);
      tick_for(3);
      send_req(MODE_STOP, 16'd0, 16'd0, 1'b0);
      send_req(MODE_TRIGGER, 16'd0, 16'd0, 1'b0);
      send_req(MODE_PASS, 16'd0, 16'd5, 1'b1);
      tick_for(2);
   endtask

   initial begin
      reset                = 1'b1;
      idling_on            = 1'b1;
      hold_request         = 0;
      hold_left            = 0;
      stall_left           = 0;
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_TICK;
      req_ch.delay_ms      = '0;
      req_ch.pass_ms       = '0;
      req_ch.pass_finished = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_MIN_INTERVAL;
      csr_ch.data          = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_run();
      test_slicing();
      test_interval_extremes();
      test_backpressure();
      test_random_mix();
      test_stop();

      settle();
      $display("Run covered %0d requests, %0d responses and %0d register writes in %0d cycles.",
               req_count, rsp_count, csr_count, cycle_count);
      $display("Checked %0d run starts: %0d sliced, %0d opening a new cycle.",
               start_count, sliced_count, fresh_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/wcdl_pkg.sv
rtl/wcdl_if.sv
rtl/wcdl_csr.sv
rtl/wcdl_in_stage.sv
rtl/wcdl_core.sv
rtl/wcdl_out_stage.sv
rtl/wakeup_coalescing_duty_limiter.sv
rtl/wcdl_checker.sv
tb/sv/tb.sv
